// File: hw/rtl/dtq_pkg.sv
// Package with shared types, codes and command structs for the delta timeout queue.
package dtq_pkg;

    // Fixed field widths.
    localparam int STATUS_W = 2;
    localparam int SENSOR_W = 16;
    localparam int TICK_W   = 32;
    localparam int WAIT_W   = 32;
    localparam int QCOUNT_W = 5;
    localparam int CFG_W    = 32;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;

    // Operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FIRE = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [TICK_W-1:0]   timeout;
        logic [TICK_W-1:0]   repeat_req;
        logic [SENSOR_W-1:0] sensor_id;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                fired_valid;
        logic [SENSOR_W-1:0] fired_sensor;
        logic                fired_first;
        logic [WAIT_W-1:0]   next_wait;
        logic [QCOUNT_W-1:0] queued_count;
    } t_out_item;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic cap;
        logic err_full;
        logic err_empty;
        logic alloc;
        logic take_free;
        logic fire_rd;
        logic pop;
        logic retire;
        logic requeue;
        logic walk_init;
        logic walk_src_link;
        logic walk_step;
        logic walk_hit;
        logic fin;
        logic link_prev;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic opcode;
        logic free_empty;
        logic list_empty;
        logic list_one;
        logic reload_zero;
        logic walk_hit;
        logic walk_last;
        logic have_prev;
        logic out_free;
    } t_dp_sts;

endpackage

// File: hw/rtl/delta_timeout_queue_unit.sv
// Top level of the delta timeout queue: sequencer plus datapath.
//
// Channel  Direction  Handshake          Beat
// in       input      valid / stall      one load or fire request
// out      output     valid / stall      one result item
// cfg      input      valid / ready      max_sleep write data
//
// A load runs DISP, LFREE, WALK, FIN, FIN2 (only when a predecessor link must be patched),
// HEADRD and RESULT; a requeuing fire runs FRD in place of LFREE. WALK passes entries until
// a later entry stops it or the list ends. A one-shot fire runs DISP, FRD, HEADRD, RESULT,
// a rejected load or fire DISP, HEADRD, RESULT; each ends before the next beat is accepted.
// Reset is synchronous; all slots are free and the list empty right after it.
// A result waits in the output register while the next beat is accepted;
// only the final result write waits on the output stall.
module delta_timeout_queue_unit #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  dtq_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output dtq_pkg::t_out_item        o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [dtq_pkg::CFG_W-1:0] i_cfg_data
);
    import dtq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // The register write is always taken.
    assign o_cfg_ready = 1'b1;

    // Sequencer.
    dtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath.
    dtq_dp #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// File: hw/rtl/dtq_ctrl.sv
// Sequencer state machine for the delta timeout queue.
module dtq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  dtq_pkg::t_dp_sts i_sts,
    output dtq_pkg::t_dp_cmd o_cmd
);
    import dtq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DISP   = 9'b000000010,
        S_LFREE  = 9'b000000100,
        S_FRD    = 9'b000001000,
        S_WALK   = 9'b000010000,
        S_FIN    = 9'b000100000,
        S_FIN2   = 9'b001000000,
        S_HEADRD = 9'b010000000,
        S_RESULT = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Input beats are taken only between operations.
    assign o_in_stall = (r_state != S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.opcode == OP_LOAD) begin
                    if (i_sts.free_empty) begin
                        o_cmd.err_full = 1'b1;
                        n_state        = S_HEADRD;
                    end else begin
                        o_cmd.alloc = 1'b1;
                        n_state     = S_LFREE;
                    end
                end else begin
                    if (i_sts.list_empty) begin
                        o_cmd.err_empty = 1'b1;
                        n_state         = S_HEADRD;
                    end else begin
                        o_cmd.fire_rd = 1'b1;
                        n_state       = S_FRD;
                    end
                end
            end
            S_LFREE: begin
                o_cmd.take_free = 1'b1;
                o_cmd.walk_init = 1'b1;
                n_state         = i_sts.list_empty ? S_FIN : S_WALK;
            end
            S_FRD: begin
                o_cmd.pop = 1'b1;
                if (i_sts.reload_zero) begin
                    o_cmd.retire = 1'b1;
                    n_state      = S_HEADRD;
                end else begin
                    o_cmd.requeue       = 1'b1;
                    o_cmd.walk_init     = 1'b1;
                    o_cmd.walk_src_link = 1'b1;
                    n_state             = i_sts.list_one ? S_FIN : S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.walk_hit) begin
                    o_cmd.walk_hit = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    if (i_sts.walk_last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = i_sts.have_prev ? S_FIN2 : S_HEADRD;
            end
            S_FIN2: begin
                o_cmd.link_prev = 1'b1;
                n_state         = S_HEADRD;
            end
            S_HEADRD: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/dtq_dp.sv
// Datapath of the delta timeout queue: entry stores, list registers and result register.
module dtq_dp #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dtq_pkg::t_in_item            i_in_data,
    input  logic                         i_cfg_valid,
    input  logic [dtq_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output dtq_pkg::t_out_item           o_out_data,
    input  dtq_pkg::t_dp_cmd             i_cmd,
    output dtq_pkg::t_dp_sts             o_sts
);
    import dtq_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TW = TIME_BITS;
    localparam int WW = (TIME_BITS > WAIT_W) ? TIME_BITS : WAIT_W;

    // Entry stores.
    logic [TW-1:0]       m_delta  [SLOTS];
    logic [TW-1:0]       m_reload [SLOTS];
    logic [SENSOR_W-1:0] m_tag    [SLOTS];
    logic                m_new    [SLOTS];
    logic [IW-1:0]       m_link   [SLOTS];
    logic [SLOTS-1:0]    r_link_vld;

    // Registered read data.
    logic [TW-1:0]       r_delta_q;
    logic [TW-1:0]       r_reload_q;
    logic [SENSOR_W-1:0] r_tag_q;
    logic                r_new_q;
    logic [IW-1:0]       r_link_raw;
    logic                r_link_v;
    logic [IW-1:0]       r_rd_addr_q;

    // Control and working registers.
    t_in_item            r_item;
    logic [STATUS_W-1:0] r_status;
    logic                r_fv;
    logic                r_ff;
    logic [SENSOR_W-1:0] r_fs;
    logic [IW-1:0]       r_slot;
    logic [IW-1:0]       r_cur;
    logic [IW-1:0]       r_prev;
    logic                r_have_prev;
    logic [TW-1:0]       r_rem;
    logic [CW-1:0]       r_i;
    logic [IW-1:0]       r_head;
    logic [IW-1:0]       r_free_head;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_free_cnt;
    logic [CFG_W-1:0]    r_max_sleep;
    logic                r_out_valid;
    t_out_item           r_out_data;

    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       link_q;
    logic                delta_we;
    logic [IW-1:0]       delta_wa;
    logic [TW-1:0]       delta_wd;
    logic                link_we;
    logic [IW-1:0]       link_wa;
    logic [IW-1:0]       link_wd;
    logic                new_we;
    logic [IW-1:0]       new_wa;
    logic [WW-1:0]       delta_w;
    logic [WW-1:0]       sleep_w;
    logic [WW-1:0]       wait_w;
    t_out_item           out_next;

    // A link entry never written reads as the reset free chain.
    always_comb begin
        if (r_link_v) begin
            link_q = r_link_raw;
        end else if (r_rd_addr_q == IW'(SLOTS - 1)) begin
            link_q = '0;
        end else begin
            link_q = r_rd_addr_q + IW'(1);
        end
    end

    // Shared read address for all stores.
    always_comb begin
        priority if (i_cmd.alloc) begin
            rd_addr = r_free_head;
        end else if (i_cmd.fire_rd) begin
            rd_addr = r_head;
        end else if (i_cmd.walk_init) begin
            rd_addr = i_cmd.walk_src_link ? link_q : r_head;
        end else if (i_cmd.walk_step) begin
            rd_addr = link_q;
        end else begin
            rd_addr = r_head;
        end
    end

    // Write port selects.
    always_comb begin
        delta_we = i_cmd.walk_hit | i_cmd.fin;
        delta_wa = i_cmd.fin ? r_slot : r_cur;
        delta_wd = i_cmd.fin ? r_rem : (r_delta_q - r_rem);
        link_we  = i_cmd.retire | i_cmd.fin | i_cmd.link_prev;
        priority if (i_cmd.retire) begin
            link_wa = r_slot;
            link_wd = r_free_head;
        end else if (i_cmd.fin) begin
            link_wa = r_slot;
            link_wd = r_cur;
        end else begin
            link_wa = r_prev;
            link_wd = r_slot;
        end
        new_we = i_cmd.alloc | i_cmd.pop;
        new_wa = i_cmd.alloc ? r_free_head : r_slot;
    end

    // Store writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (delta_we) begin
            m_delta[delta_wa] <= delta_wd;
        end
        if (i_cmd.alloc) begin
            m_reload[r_free_head] <= TW'(r_item.repeat_req);
            m_tag[r_free_head]    <= r_item.sensor_id;
        end
        if (new_we) begin
            m_new[new_wa] <= i_cmd.alloc;
        end
        if (link_we) begin
            m_link[link_wa] <= link_wd;
        end
        r_delta_q   <= m_delta[rd_addr];
        r_reload_q  <= m_reload[rd_addr];
        r_tag_q     <= m_tag[rd_addr];
        r_new_q     <= m_new[rd_addr];
        r_link_raw  <= m_link[rd_addr];
        r_rd_addr_q <= rd_addr;
    end

    // List bookkeeping, link valid bits, config and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld  <= '0;
            r_link_v    <= 1'b0;
            r_head      <= '0;
            r_count     <= '0;
            r_free_head <= '0;
            r_free_cnt  <= CW'(SLOTS);
            r_max_sleep <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_link_v <= r_link_vld[rd_addr];
            if (link_we) begin
                r_link_vld[link_wa] <= 1'b1;
            end
            if (i_cfg_valid) begin
                r_max_sleep <= i_cfg_data;
            end
            if (i_cmd.pop) begin
                r_head  <= link_q;
                r_count <= r_count - CW'(1);
            end else if (i_cmd.fin && !r_have_prev) begin
                r_head  <= r_slot;
                r_count <= r_count + CW'(1);
            end else if (i_cmd.link_prev) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.take_free) begin
                r_free_head <= link_q;
                r_free_cnt  <= r_free_cnt - CW'(1);
            end else if (i_cmd.retire) begin
                r_free_head <= r_slot;
                r_free_cnt  <= r_free_cnt + CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the current operation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_item   <= i_in_data;
            r_status <= ST_OK;
            r_fv     <= 1'b0;
            r_ff     <= 1'b0;
            r_fs     <= '0;
        end
        if (i_cmd.err_full) begin
            r_status <= ST_NO_SLOT;
        end
        if (i_cmd.err_empty) begin
            r_status <= ST_EMPTY;
        end
        if (i_cmd.alloc) begin
            r_slot <= r_free_head;
            r_rem  <= TW'(r_item.timeout);
        end
        if (i_cmd.fire_rd) begin
            r_slot <= r_head;
        end
        if (i_cmd.pop) begin
            r_fv <= 1'b1;
            r_fs <= r_tag_q;
            r_ff <= r_new_q;
        end
        if (i_cmd.requeue) begin
            r_rem <= r_reload_q;
        end
        if (i_cmd.walk_init) begin
            r_cur       <= i_cmd.walk_src_link ? link_q : r_head;
            r_have_prev <= 1'b0;
            r_i         <= '0;
        end
        if (i_cmd.walk_step) begin
            r_rem       <= r_rem - r_delta_q;
            r_prev      <= r_cur;
            r_have_prev <= 1'b1;
            r_cur       <= link_q;
            r_i         <= r_i + CW'(1);
        end
        if (i_cmd.emit) begin
            r_out_data <= out_next;
        end
    end

    // Next wait: head delta capped by the sleep limit.
    always_comb begin
        delta_w = WW'(r_delta_q);
        sleep_w = WW'(r_max_sleep);
        if ((r_count != '0) && (delta_w < sleep_w)) begin
            wait_w = delta_w;
        end else begin
            wait_w = sleep_w;
        end
        out_next.status       = r_status;
        out_next.fired_valid  = r_fv;
        out_next.fired_sensor = r_fs;
        out_next.fired_first  = r_ff;
        out_next.next_wait    = wait_w[WAIT_W-1:0];
        out_next.queued_count = QCOUNT_W'(r_count);
    end

    // Status to the sequencer.
    always_comb begin
        o_sts.opcode      = r_item.opcode;
        o_sts.free_empty  = (r_free_cnt == '0);
        o_sts.list_empty  = (r_count == '0);
        o_sts.list_one    = (r_count == CW'(1));
        o_sts.reload_zero = (r_reload_q == '0);
        o_sts.walk_hit    = (r_delta_q > r_rem);
        o_sts.walk_last   = ((r_i + CW'(1)) == r_count);
        o_sts.have_prev   = r_have_prev;
        o_sts.out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the delta timeout queue unit.
`timescale 1ns / 1ps

module tb_top;
    import dtq_pkg::*;

    localparam int NSLOT     = 16;
    localparam int WD_LIMIT  = 20000;
    localparam int RAND_ITEMS = 1500;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    delta_timeout_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Shadow copy of the timer pool.
    logic [TICK_W-1:0]   sh_delta [NSLOT];
    logic [TICK_W-1:0]   sh_reload [NSLOT];
    logic [SENSOR_W-1:0] sh_tag [NSLOT];
    logic                sh_new [NSLOT];
    int                  sh_link [NSLOT];
    int                  sh_head, sh_count, sh_free_head, sh_free_count;
    logic [CFG_W-1:0]    sh_max_sleep;

    t_out_item pending_results[$];
    int  errors;
    int  idle_pct_in, stall_pct_out;
    int  quiet_cycles;
    bit  timed_out;

    // Reset the shadow pool.
    function automatic void pool_reset();
        for (int i = 0; i < NSLOT; i++) begin
            sh_delta[i] = '0;
            sh_reload[i] = '0;
            sh_tag[i] = '0;
            sh_new[i] = 1'b0;
            sh_link[i] = (i + 1 < NSLOT) ? i + 1 : 0;
        end
        sh_head = 0;
        sh_count = 0;
        sh_free_head = 0;
        sh_free_count = NSLOT;
        sh_max_sleep = '1;
    endfunction

    // Insert a slot into the delta list after entries with an equal deadline.
    function automatic void pool_insert(int slot);
        logic [TICK_W-1:0] rem;
        int prev;
        bit have_prev;
        int cur;
        rem = sh_delta[slot];
        prev = 0;
        have_prev = 0;
        cur = sh_head;
        for (int i = 0; i < sh_count; i++) begin
            if (sh_delta[cur] > rem) begin
                sh_delta[cur] -= rem;
                break;
            end
            rem -= sh_delta[cur];
            prev = cur;
            have_prev = 1;
            cur = sh_link[cur];
        end
        sh_delta[slot] = rem;
        sh_link[slot] = cur;
        if (have_prev)
            sh_link[prev] = slot;
        else
            sh_head = slot;
        sh_count++;
    endfunction

    // Apply one request to the shadow pool and return the result it yields.
    function automatic t_out_item pool_apply(t_in_item req);
        t_out_item res;
        int slot;
        res = '0;
        res.status = ST_OK;
        if (req.opcode == OP_LOAD) begin
            if (sh_free_count == 0) begin
                res.status = ST_NO_SLOT;
            end else begin
                slot = sh_free_head;
                sh_free_head = sh_link[slot];
                sh_free_count--;
                sh_delta[slot] = req.timeout;
                sh_reload[slot] = req.repeat_req;
                sh_tag[slot] = req.sensor_id;
                sh_new[slot] = 1'b1;
                pool_insert(slot);
            end
        end else begin
            if (sh_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                slot = sh_head;
                res.fired_valid = 1'b1;
                res.fired_sensor = sh_tag[slot];
                res.fired_first = sh_new[slot];
                sh_new[slot] = 1'b0;
                sh_head = sh_link[slot];
                sh_count--;
                if (sh_reload[slot] != 0) begin
                    sh_delta[slot] = sh_reload[slot];
                    pool_insert(slot);
                end else begin
                    sh_link[slot] = sh_free_head;
                    sh_free_head = slot;
                    sh_free_count++;
                end
            end
        end
        res.next_wait = sh_max_sleep;
        if (sh_count != 0 && sh_delta[sh_head] < sh_max_sleep)
            res.next_wait = sh_delta[sh_head];
        res.queued_count = QCOUNT_W'(sh_count);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Result checker at the rising edge; a result counts as taken when it is not stalled.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_out_data, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.fired_valid !== want.fired_valid)
                    report_mismatch("fired_valid", o_out_data.fired_valid, want.fired_valid);
                if (o_out_data.fired_sensor !== want.fired_sensor)
                    report_mismatch("fired_sensor", o_out_data.fired_sensor,
                                    want.fired_sensor);
                if (o_out_data.fired_first !== want.fired_first)
                    report_mismatch("fired_first", o_out_data.fired_first, want.fired_first);
                if (o_out_data.next_wait !== want.next_wait)
                    report_mismatch("next_wait", o_out_data.next_wait, want.next_wait);
                if (o_out_data.queued_count !== want.queued_count)
                    report_mismatch("queued_count", o_out_data.queued_count,
                                    want.queued_count);
            end
        end
    end

    // Receiver stall pattern changes at the falling edge.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct_out);
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("Watchdog expired at %0t", $realtime);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Send one request beat and record its expected result.
    // Valid drops only in idle cycles or when the stimulus ends.
    task automatic send_item(t_in_item req, bit has_want, t_out_item want);
        t_out_item pred;
        while ($urandom_range(99) < idle_pct_in) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pred = pool_apply(req);
        if (has_want && pred !== want)
            report_mismatch("directed row vs predictor", pred, want);
        pending_results.push_back(pred);
        @(negedge i_clk);
    endtask

    // Let all results drain, then some extra cycles for the block to settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_max_sleep(logic [CFG_W-1:0] val);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sh_max_sleep = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item mk(logic op, logic [31:0] tmo, logic [31:0] rep,
                                    logic [15:0] tag);
        t_in_item r;
        r.opcode = op;
        r.timeout = tmo;
        r.repeat_req = rep;
        r.sensor_id = tag;
        return r;
    endfunction

    // Random timeout with a bias toward small and equal deadlines.
    function automatic logic [31:0] rand_ticks();
        case ($urandom_range(3))
            0: return $urandom_range(3);
            1: return $urandom_range(100);
            2: return $urandom;
            default: return 32'hFFFF_FFFF - $urandom_range(3);
        endcase
    endfunction

    typedef struct {
        t_in_item  req;
        bit        has_want;
        t_out_item want;
    } t_row;

    initial begin
        t_row rows[$];
        t_row row;
        t_in_item req;
        int phase;
        int load_pct;
        errors = 0;
        timed_out = 0;
        idle_pct_in = 0;
        stall_pct_out = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        pool_reset();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows: empty fire, extremes, equal deadlines, full pool.
        row.has_want = 1;
        row.req = mk(OP_FIRE, 0, 0, 0);
        row.want = '{status: ST_EMPTY, fired_valid: 0, fired_sensor: 0, fired_first: 0,
                     next_wait: 32'hFFFF_FFFF, queued_count: 0};
        rows.push_back(row);
        row.req = mk(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        row.want = '{status: ST_OK, fired_valid: 0, fired_sensor: 0, fired_first: 0,
                     next_wait: 32'hFFFF_FFFF, queued_count: 1};
        rows.push_back(row);
        row.req = mk(OP_FIRE, 0, 0, 0);
        row.want = '{status: ST_OK, fired_valid: 1, fired_sensor: 16'hFFFF, fired_first: 1,
                     next_wait: 32'hFFFF_FFFF, queued_count: 1};
        rows.push_back(row);
        row.has_want = 0;
        row.req = mk(OP_LOAD, 0, 0, 16'h0000);
        rows.push_back(row);
        row.req = mk(OP_LOAD, 5, 7, 16'h1234);
        rows.push_back(row);
        row.req = mk(OP_LOAD, 5, 0, 16'h5678);
        rows.push_back(row);
        for (int i = 0; i < 14; i++) begin
            row.req = mk(OP_LOAD, 32'(i * 3), 32'(i & 1), 16'(16'hA000 + i));
            rows.push_back(row);
        end
        for (int i = 0; i < 5; i++) begin
            row.req = mk(OP_FIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
            rows.push_back(row);
        end
        foreach (rows[i])
            send_item(rows[i].req, rows[i].has_want, rows[i].want);

        // Random phases with different idling and max_sleep settings.
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_max_sleep(32'd0);
                1: write_max_sleep(32'd50);
                2: write_max_sleep(32'hFFFF_FFFF);
                3: write_max_sleep($urandom);
                4: write_max_sleep(32'd3);
                default: write_max_sleep(32'hFFFF_FFFF);
            endcase
            case (phase % 4)
                0: begin idle_pct_in = 0;  stall_pct_out = 0;  end
                1: begin idle_pct_in = 66; stall_pct_out = 0;  end
                2: begin idle_pct_in = 0;  stall_pct_out = 66; end
                default: begin idle_pct_in = 25; stall_pct_out = 25; end
            endcase
            for (int n = 0; n < RAND_ITEMS / 6; n++) begin
                // Drift between filling and emptying so both ends are reached.
                load_pct = ((n / 60) % 2 == 0) ? 70 : 30;
                req.opcode = ($urandom_range(99) < load_pct) ? OP_LOAD : OP_FIRE;
                req.timeout = rand_ticks();
                req.repeat_req = ($urandom_range(2) == 0) ? 32'd0 : rand_ticks();
                req.sensor_id = $urandom;
                send_item(req, 0, '0);
            end
        end
        idle_pct_in = 0;
        stall_pct_out = 0;
        drain_results();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
